@@ rtl/core/keyframe_vertex_morph_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef KEYFRAME_VERTEX_MORPH_TOP_ASSERT_SVH
`define KEYFRAME_VERTEX_MORPH_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define KVM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off while reset is asserted.
`define KVM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/core/kvm_pkg.sv @@
`timescale 1ns / 1ps
package kvm_pkg;

  localparam int COORD_W  = 16;
  localparam int COORDS   = 3;
  localparam int VERT_W   = COORD_W * COORDS;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic [1:0] KIND_VERT   = 2'd0;
  localparam logic [1:0] KIND_CORNER = 2'd1;
  localparam logic [1:0] KIND_MORPH  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNERS = 2'd2;

  // Result status
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Stage enables of the arithmetic lanes
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } lane_en_t;

endpackage

@@ rtl/core/kvm_lane.sv @@
`timescale 1ns / 1ps
module kvm_lane import kvm_pkg::*; (
  input  logic                      clk_i,
  input  lane_en_t                  en_i,
  input  logic signed [COORD_W-1:0] a_i,
  input  logic signed [COORD_W-1:0] b_i,
  input  logic        [7:0]         weight_i,
  input  logic                      bad_i,
  output logic signed [COORD_W-1:0] res_o
);

  logic signed [COORD_W:0]    diff_q;
  logic signed [COORD_W-1:0]  a4_q;
  logic        [7:0]          w4_q;
  logic signed [24:0]         prod_d;
  logic signed [24:0]         prod_q;
  logic signed [COORD_W-1:0]  a5_q;
  logic signed [COORD_W-1:0]  res_q;

  // w < 256 so the product fits 25 signed bits
  assign prod_d = $signed({16'd0, w4_q}) * $signed({{8{diff_q[COORD_W]}}, diff_q});

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      diff_q <= {b_i[COORD_W-1], b_i} - {a_i[COORD_W-1], a_i};
      a4_q   <= a_i;
      w4_q   <= weight_i;
    end
    if (en_i.s5) begin
      prod_q <= prod_d;
      a5_q   <= a4_q;
    end
    // floor shift by 8; the sum always lies between a and b
    if (en_i.s6) begin
      res_q <= bad_i ? '0 : a5_q + prod_q[23:8];
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/core/keyframe_vertex_morph_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | kind, frame, next_frame, vertex, corner,
//         |           |                        | pos_x/y/z, weight
// out     | output    | out_valid_o/out_ready_i| out_corner, out_x/y/z, status
// cfg     | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One request per cycle unless a stalled output holds the pipeline; a morph result passes through the stages below.
// Six register stages: input, corner table read, vertex store read (two ports),
// difference, product, sum into the output register.
// Each stage advances when it is empty or the next one advances, so bubbles close up.
// Reset clears the valid bits and loads the register defaults; the stores are not cleared.
module keyframe_vertex_morph_top import kvm_pkg::*; #(
  parameter int MAX_VERTS   = 256,
  parameter int MAX_FRAMES  = 64,
  parameter int MAX_CORNERS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [5:0]                  frame_i,
  input  logic [5:0]                  next_frame_i,
  input  logic [7:0]                  vertex_i,
  input  logic [11:0]                 corner_i,
  input  logic signed [COORD_W-1:0]   pos_x_i,
  input  logic signed [COORD_W-1:0]   pos_y_i,
  input  logic signed [COORD_W-1:0]   pos_z_i,
  input  logic [7:0]                  weight_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [11:0]                 out_corner_o,
  output logic signed [COORD_W-1:0]   out_x_o,
  output logic signed [COORD_W-1:0]   out_y_o,
  output logic signed [COORD_W-1:0]   out_z_o,
  output logic                        status_o
);

  localparam int VS_DEPTH = MAX_FRAMES * MAX_VERTS;
  localparam int VS_AW    = $clog2(VS_DEPTH);
  localparam int CT_AW    = $clog2(MAX_CORNERS);
  localparam logic [10:0] VLIM_MAX = 11'(MAX_VERTS);
  localparam logic [8:0]  FLIM_MAX = 9'(MAX_FRAMES);
  localparam logic [14:0] CLIM_MAX = 15'(MAX_CORNERS);

  // configuration
  logic [8:0]  verts_q;
  logic [6:0]  frames_q;
  logic [12:0] corners_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      verts_q   <= 9'd256;
      frames_q  <= 7'd64;
      corners_q <= 13'd4096;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VERTS:   verts_q   <= cfg_wdata_i[8:0];
        CFG_FRAMES:  frames_q  <= cfg_wdata_i[6:0];
        CFG_CORNERS: corners_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic en1, en2, en3, en4, en5, en6;

  assign en6 = !v6_q || out_ready_i;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  // stage 1: input register
  logic [1:0]          kind1_q;
  logic [5:0]          frame1_q, nframe1_q;
  logic [7:0]          vtx1_q;
  logic [11:0]         corner1_q;
  logic [VERT_W-1:0]   pos1_q;
  logic [7:0]          w1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind1_q   <= kind_i;
      frame1_q  <= frame_i;
      nframe1_q <= next_frame_i;
      vtx1_q    <= vertex_i;
      corner1_q <= corner_i;
      pos1_q    <= {pos_z_i, pos_y_i, pos_x_i};
      w1_q      <= weight_i;
    end
  end

  logic c_ok1, f_ok1, nf_ok1, vtx_ok1, is_vert1, is_corner1, is_morph1;
  logic ct_we1;
  logic [CT_AW-1:0] ct_addr1;

  assign c_ok1   = ({1'b0, corner1_q} < corners_q) && ({3'b0, corner1_q} < CLIM_MAX);
  assign f_ok1   = ({1'b0, frame1_q} < frames_q) && ({3'b0, frame1_q} < FLIM_MAX);
  assign nf_ok1  = ({1'b0, nframe1_q} < frames_q) && ({3'b0, nframe1_q} < FLIM_MAX);
  assign vtx_ok1 = ({1'b0, vtx1_q} < verts_q) && ({3'b0, vtx1_q} < VLIM_MAX);
  assign is_vert1   = (kind1_q == KIND_VERT);
  assign is_corner1 = (kind1_q == KIND_CORNER);
  assign is_morph1  = (kind1_q == KIND_MORPH);
  assign ct_addr1   = CT_AW'(corner1_q);
  assign ct_we1     = en2 && v1_q && is_corner1 && c_ok1 && vtx_ok1;

  // corner table: written and read as the request leaves stage 1
  logic [7:0] ct_mem_q [MAX_CORNERS];
  logic [7:0] ct_rd_q;

  always_ff @(posedge clk_i) begin
    if (ct_we1) begin
      ct_mem_q[ct_addr1] <= vtx1_q;
    end
    if (en2) begin
      ct_rd_q <= ct_mem_q[ct_addr1];
    end
  end

  // stage 2: corner lookup done, frame bases ready
  logic               morph2_q, bad2_q;
  logic [VS_AW-1:0]   base_a2_q, base_b2_q;
  logic [7:0]         vtx2_q;
  logic [11:0]        corner2_q;
  logic [VERT_W-1:0]  pos2_q;
  logic [7:0]         w2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      morph2_q  <= is_morph1;
      bad2_q    <= !(c_ok1 && f_ok1 && nf_ok1);
      base_a2_q <= VS_AW'(32'(frame1_q) * MAX_VERTS);
      base_b2_q <= VS_AW'(32'(nframe1_q) * MAX_VERTS);
      vtx2_q    <= vtx1_q;
      corner2_q <= corner1_q;
      pos2_q    <= pos1_q;
      w2_q      <= w1_q;
    end
  end

  logic [7:0]       vsel2;
  logic             v_ok2;
  logic [VS_AW-1:0] addr_a2, addr_b2;
  logic             vs_we2;

  assign vsel2   = morph2_q ? ct_rd_q : vtx2_q;
  assign v_ok2   = ({1'b0, vsel2} < verts_q) && ({3'b0, vsel2} < VLIM_MAX);
  assign addr_a2 = base_a2_q + VS_AW'(vsel2);
  assign addr_b2 = base_b2_q + VS_AW'(vsel2);
  assign vs_we2  = en3 && v2_q && !morph2_q;

  // vertex store: one write port, two read ports, used as the request leaves stage 2
  logic [VERT_W-1:0] vs_mem_q [VS_DEPTH];
  logic [VERT_W-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (vs_we2) begin
      vs_mem_q[addr_a2] <= pos2_q;
    end
    if (en3) begin
      rd_a_q <= vs_mem_q[addr_a2];
      rd_b_q <= vs_mem_q[addr_b2];
    end
  end

  // stage 3 to 6: control that travels beside the lanes
  logic        bad3_q, bad4_q, bad5_q, bad6_q;
  logic [11:0] corner3_q, corner4_q, corner5_q, corner6_q;
  logic [7:0]  w3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      bad3_q    <= bad2_q || !v_ok2;
      corner3_q <= corner2_q;
      w3_q      <= w2_q;
    end
    if (en4) begin
      bad4_q    <= bad3_q;
      corner4_q <= corner3_q;
    end
    if (en5) begin
      bad5_q    <= bad4_q;
      corner5_q <= corner4_q;
    end
    if (en6) begin
      bad6_q    <= bad5_q;
      corner6_q <= corner5_q;
    end
  end

  // valids: only morph requests stay valid past stage 2; loads and unused kinds drop out earlier
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q && (is_morph1 || (is_vert1 && f_ok1 && vtx_ok1));
      if (en3) v3_q <= v2_q && morph2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  lane_en_t                        lane_en;
  logic [COORDS-1:0][COORD_W-1:0]  res;

  assign lane_en.s4 = en4;
  assign lane_en.s5 = en5;
  assign lane_en.s6 = en6;

  for (genvar g = 0; g < COORDS; g++) begin : g_lane
    kvm_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (lane_en),
      .a_i      ($signed(rd_a_q[g*COORD_W +: COORD_W])),
      .b_i      ($signed(rd_b_q[g*COORD_W +: COORD_W])),
      .weight_i (w3_q),
      .bad_i    (bad5_q),
      .res_o    (res[g])
    );
  end

  assign out_valid_o  = v6_q;
  assign out_corner_o = corner6_q;
  assign out_x_o      = $signed(res[0]);
  assign out_y_o      = $signed(res[1]);
  assign out_z_o      = $signed(res[2]);
  assign status_o     = bad6_q ? STATUS_ERR : STATUS_OK;

endmodule

@@ rtl/core/kvm_checker.sv @@
`timescale 1ns / 1ps
`include "keyframe_vertex_morph_top_assert.svh"
module kvm_checker import kvm_pkg::*; (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [11:0]                out_corner_o,
  input logic signed [COORD_W-1:0]  out_x_o,
  input logic signed [COORD_W-1:0]  out_y_o,
  input logic signed [COORD_W-1:0]  out_z_o,
  input logic                       status_o
);

  logic                   err_out;
  logic                   zero_xyz;
  logic                   out_stall;
  logic [12+3*COORD_W:0]  out_bits;

  assign err_out   = out_valid_o && (status_o == STATUS_ERR);
  assign zero_xyz  = (out_x_o == '0) && (out_y_o == '0) && (out_z_o == '0);
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_bits  = {out_corner_o, out_x_o, out_y_o, out_z_o, status_o};

  // an error result carries zero coordinates
  `KVM_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, err_out, zero_xyz)

  // with nothing waiting at the output the pipeline takes requests
  `KVM_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

  // an accepted result leaves room for the next request
  `KVM_ASSERT_IMPL(a_ready_on_drain, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)

  // hold a stalled result
  `KVM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_bits))

endmodule

bind keyframe_vertex_morph_top kvm_checker u_kvm_checker (.*);
